// ----- rtl/core/sapc_pkg.sv -----
package sapc_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned CountWidth   = 32;
  localparam int unsigned AddrWidth    = 32;
  localparam int unsigned SlotWidth    = 8;
  localparam int unsigned PosWidth     = 16;
  localparam logic [PosWidth-1:0] PosMax    = 16'hFFFF;
  localparam logic [PosWidth-1:0] AddrFirst = 16'd26;
  localparam logic [PosWidth-1:0] AddrLast  = 16'd29;
  localparam logic [PosWidth-1:0] MinFrame  = 16'd30;

  typedef enum logic [1:0] {
    StHit   = 2'd0,
    StNew   = 2'd1,
    StFull  = 2'd2,
    StShort = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle   = 3'b001,
    FsmSearch = 3'b010,
    FsmOut    = 3'b100
  } fsm_e;

  // word travelling along the cell row
  typedef struct packed {
    logic                 active;
    logic                 found;
    logic [AddrWidth-1:0] addr;
  } probe_t;

endpackage

// ----- rtl/core/source_address_packet_counter_core.sv -----
// Result: a counted frame's result is valid once the probe has walked the cell
// row, a short frame's in the cycle after its last byte is taken; capture off
// gives none. Throughput: one byte per cycle inside a frame; after a captured
// last byte input stalls until the result is taken, for a counted frame also
// until the probe has walked the cell row. Reset: asynchronous, active low;
// table empty, byte position zero, capture enabled.
module source_address_packet_counter_core #(
  parameter int unsigned TABLE_ENTRIES = sapc_pkg::TableEntries,
  parameter int unsigned COUNT_WIDTH   = sapc_pkg::CountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    frame_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [sapc_pkg::SlotWidth-1:0] slot_o,
  output logic [sapc_pkg::AddrWidth-1:0] source_address_o,
  output logic [31:0]                   packet_count_o
);
  import sapc_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  fsm_e                 fsm_q, fsm_d;
  logic                 cap_q;
  logic [PosWidth-1:0]  pos_q;
  logic [AddrWidth-1:0] sh_q, sh_next;
  logic [CntW-1:0]      walk_q;
  logic [1:0]           st_q;
  logic [IdxW-1:0]      slot_q;
  logic [AddrWidth-1:0] addr_q;
  logic [31:0]          pc_q;
  logic                 acc, start, start_short, short_frame;
  probe_t               probe0_q;

  probe_t               probe [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] hit, used;
  logic [COUNT_WIDTH-1:0]   cnt [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] tail;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (fsm_q != FsmIdle);
  assign acc         = in_valid_i && !in_stall_o;
  assign sh_next     = (pos_q >= AddrFirst && pos_q <= AddrLast) ?
                       {sh_q[AddrWidth-9:0], frame_byte_i} : sh_q;
  // byte count is position + 1; compare the position so a saturated one cannot wrap
  assign short_frame = (pos_q < (MinFrame - 16'd1));
  assign start_short = acc && last_byte_i && cap_q && short_frame;
  assign start       = acc && last_byte_i && cap_q && !short_frame;

  assign probe[0] = probe0_q;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    assign tail[g] = (g == 0) ? 1'b1 : used[(g == 0) ? 0 : g-1];
    sapc_cell #(.CountWidth(COUNT_WIDTH)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .clear_i   (1'b0),
      .probe_i   (probe[g]),
      .is_tail_i (tail[g]),
      .probe_o   (probe[g+1]),
      .hit_o     (hit[g]),
      .count_o   (cnt[g]),
      .used_o    (used[g])
    );
  end

  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      FsmIdle:   if (start) fsm_d = FsmSearch;
                 else if (start_short) fsm_d = FsmOut;
      FsmSearch: if (walk_q == CntW'(TABLE_ENTRIES)) fsm_d = FsmOut;
      FsmOut:    if (!out_stall_i) fsm_d = FsmIdle;
      default:   fsm_d = FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q    <= FsmIdle;
      cap_q    <= 1'b1;
      pos_q    <= '0;
      sh_q     <= '0;
      walk_q   <= '0;
      probe0_q <= '0;
    end else begin
      fsm_q <= fsm_d;
      probe0_q.active <= start;
      probe0_q.found  <= 1'b0;
      probe0_q.addr   <= sh_next;
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (acc) begin
        if (last_byte_i) begin
          pos_q <= '0;
          sh_q  <= '0;
        end else begin
          sh_q <= sh_next;
          if (pos_q != PosMax) pos_q <= pos_q + 16'd1;
        end
      end
      if (fsm_q == FsmSearch) walk_q <= walk_q + 1'b1;
      else walk_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_short) begin
      st_q   <= StShort;
      slot_q <= '0;
      addr_q <= '0;
      pc_q   <= '0;
    end else if (start) begin
      st_q   <= StFull;
      slot_q <= '0;
      addr_q <= sh_next;
      pc_q   <= '0;
    end else if (fsm_q == FsmSearch) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        if (hit[k]) begin
          st_q   <= probe[k].found ? StHit : (used[k] ? StHit : StNew);
          slot_q <= IdxW'(k);
          pc_q   <= 32'(cnt[k]);
        end
      end
    end
  end

  assign out_valid_o      = (fsm_q == FsmOut);
  assign status_o         = st_q;
  assign slot_o           = SlotWidth'(slot_q);
  assign source_address_o = addr_q;
  assign packet_count_o   = pc_q;

endmodule

// ----- rtl/core/sapc_cell.sv -----
module sapc_cell #(
  parameter int unsigned CountWidth = sapc_pkg::CountWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  sapc_pkg::probe_t      probe_i,
  input  logic                  is_tail_i,
  output sapc_pkg::probe_t      probe_o,
  output logic                  hit_o,
  output logic [CountWidth-1:0] count_o,
  output logic                  used_o
);
  import sapc_pkg::*;

  logic                  used_q, used_d;
  logic [AddrWidth-1:0]  addr_q, addr_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  probe_t                probe_q, probe_d;
  logic                  match, take;

  assign match = probe_i.active && !probe_i.found && used_q && (addr_q == probe_i.addr);
  assign take  = probe_i.active && !probe_i.found && !used_q && is_tail_i;

  always_comb begin
    used_d  = used_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    probe_d = probe_i;
    if (clear_i) begin
      probe_d.active = 1'b0;
    end
    if (match) begin
      if (cnt_q != {CountWidth{1'b1}}) begin
        cnt_d = cnt_q + 1'b1;
      end
      probe_d.found = 1'b1;
    end else if (take) begin
      used_d        = 1'b1;
      addr_d        = probe_i.addr;
      cnt_d         = {{(CountWidth-1){1'b0}}, 1'b1};
      probe_d.found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      probe_q <= '0;
    end else begin
      used_q  <= used_d;
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
  end

  assign probe_o = probe_q;
  assign hit_o   = match || take;
  assign count_o = cnt_d;
  assign used_o  = used_q;

endmodule
